FILE: hdl/sda_pkg.sv
// ----------------------------------------------------------------------------
// sda_pkg
// shared widths, register map and reset values of the stream decoder assigner
// ----------------------------------------------------------------------------
package sda_pkg;

	localparam int IN_W       = 16;
	localparam int SLOT_IDX_W = 3;
	localparam int SRC_W      = 4;
	localparam int SURPLUS_W  = 5;
	localparam int DEC_W      = 4;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	localparam logic [DEC_W-1:0] DEC_RESET = 4'd8;

	// register index taken from paddr[2]
	localparam logic REG_DECODERS_IN_USE = 1'b0;

endpackage

FILE: hdl/sda_round_if.sv
// ----------------------------------------------------------------------------
// sda_round_if
// round request channel: mask of input channels with samples waiting
// ----------------------------------------------------------------------------
interface sda_round_if
	import sda_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] input_has_samples;

	modport source (output valid, output input_has_samples, input ready);
	modport sink (input valid, input input_has_samples, output ready);
endinterface

FILE: hdl/sda_slot_if.sv
// ----------------------------------------------------------------------------
// sda_slot_if
// slot result channel: one word per decoder slot per round
// ----------------------------------------------------------------------------
interface sda_slot_if
	import sda_pkg::*;
();
	logic                        valid;
	logic                        ready;
	logic [SLOT_IDX_W-1:0]       slot_index;
	logic                        slot_enabled;
	logic                        slot_busy;
	logic [SRC_W-1:0]            source_input;
	logic                        newly_assigned;
	logic signed [SURPLUS_W-1:0] round_surplus;
	logic                        last_result;

	modport source (
		output valid, output slot_index, output slot_enabled, output slot_busy,
		output source_input, output newly_assigned, output round_surplus,
		output last_result, input ready
	);
	modport sink (
		input valid, input slot_index, input slot_enabled, input slot_busy,
		input source_input, input newly_assigned, input round_surplus,
		input last_result, output ready
	);
endinterface

FILE: hdl/sda_cfg.sv
// ----------------------------------------------------------------------------
// sda_cfg
// apb register block holding the number of connected decoder slots
// ----------------------------------------------------------------------------
module sda_cfg
	import sda_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [DEC_W-1:0]      decoders_in_use
);

	logic [DEC_W-1:0] dec_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= DEC_RESET;
		end else if (wr_en && (paddr[2] == REG_DECODERS_IN_USE)) begin
			dec_q <= pwdata[DEC_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DECODERS_IN_USE: prdata = CFG_DATA_W'(dec_q);
			default:             prdata = '0;
		endcase
	end

	assign decoders_in_use = dec_q;

endmodule

FILE: hdl/sda_core.sv
// ----------------------------------------------------------------------------
// sda_core
// slot table with a single walker that releases, assigns and reports slots
// ----------------------------------------------------------------------------
module sda_core
	import sda_pkg::*;
#(
	parameter int NUM_INPUTS   = 16,
	parameter int NUM_DECODERS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DEC_W-1:0] decoders_in_use,
	sda_round_if.sink        rnd,
	sda_slot_if.source       res
);

	localparam int IN_LIM = (NUM_INPUTS > IN_W) ? IN_W : NUM_INPUTS;
	localparam int CW0    = $clog2(NUM_DECODERS + 1);
	localparam int CW     = (CW0 > DEC_W) ? CW0 : DEC_W;
	localparam int SW     = (NUM_DECODERS > 1) ? $clog2(NUM_DECODERS) : 1;
	localparam int IW     = $clog2(IN_LIM + 1);
	localparam int SPW0   = $clog2(NUM_DECODERS + IN_LIM + 1) + 1;
	localparam int SPW    = (SPW0 > SURPLUS_W) ? SPW0 : SURPLUS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RELEASE,
		ST_ASSIGN,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic [NUM_DECODERS-1:0] busy_q;
	logic [SRC_W-1:0]        src_q [NUM_DECODERS];
	logic [NUM_DECODERS-1:0] fresh_q;
	logic [IN_W-1:0]         waiting_q;
	logic [IN_W-1:0]         held_q;
	logic [CW-1:0]           slot_q;
	logic [IW-1:0]           inp_q;
	logic signed [SPW-1:0]   surplus_q;

	logic                        oval_q;
	logic [SLOT_IDX_W-1:0]       oidx_q;
	logic                        oen_q;
	logic                        obusy_q;
	logic [SRC_W-1:0]            osrc_q;
	logic                        ofresh_q;
	logic signed [SURPLUS_W-1:0] osurp_q;
	logic                        olast_q;

	logic [CW-1:0]    en;
	logic [SW-1:0]    sidx;
	logic [3:0]       inp_idx;
	logic             cur_busy;
	logic [SRC_W-1:0] cur_src;
	logic             slot_last;

	assign en        = (CW'(decoders_in_use) > CW'(NUM_DECODERS)) ?
	                   CW'(NUM_DECODERS) : CW'(decoders_in_use);
	assign sidx      = slot_q[SW-1:0];
	assign inp_idx   = 4'(inp_q);
	assign cur_busy  = busy_q[sidx];
	assign cur_src   = src_q[sidx];
	assign slot_last = (slot_q == CW'(NUM_DECODERS - 1));

	assign rnd.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			busy_q    <= '0;
			for (int k = 0; k < NUM_DECODERS; k++) begin
				src_q[k] <= '0;
			end
			fresh_q   <= '0;
			waiting_q <= '0;
			held_q    <= '0;
			slot_q    <= '0;
			inp_q     <= '0;
			surplus_q <= '0;
			oval_q    <= 1'b0;
		end else begin
			if (res.ready && (state_q != ST_EMIT)) begin
				oval_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (rnd.valid) begin
						waiting_q <= rnd.input_has_samples;
						held_q    <= '0;
						fresh_q   <= '0;
						surplus_q <= '0;
						slot_q    <= '0;
						state_q   <= ST_RELEASE;
					end
				end
				ST_RELEASE: begin
					if (slot_q >= en) begin
						busy_q[sidx] <= 1'b0;
						src_q[sidx]  <= '0;
					end else if (cur_busy && !waiting_q[cur_src]) begin
						busy_q[sidx] <= 1'b0;
						src_q[sidx]  <= '0;
						surplus_q    <= surplus_q + SPW'(1);
					end else if (cur_busy) begin
						held_q[cur_src] <= 1'b1;
					end
					if (slot_last) begin
						slot_q  <= '0;
						inp_q   <= '0;
						state_q <= ST_ASSIGN;
					end else begin
						slot_q <= slot_q + CW'(1);
					end
				end
				ST_ASSIGN: begin
					if (inp_q == IW'(IN_LIM)) begin
						slot_q  <= '0;
						state_q <= ST_EMIT;
					end else if (!waiting_q[inp_idx] || held_q[inp_idx]) begin
						inp_q <= inp_q + IW'(1);
					end else if (slot_q >= en) begin
						surplus_q <= surplus_q - SPW'(1);
						inp_q     <= inp_q + IW'(1);
					end else if (cur_busy) begin
						slot_q <= slot_q + CW'(1);
					end else begin
						busy_q[sidx]  <= 1'b1;
						src_q[sidx]   <= SRC_W'(inp_q);
						fresh_q[sidx] <= 1'b1;
						slot_q        <= slot_q + CW'(1);
						inp_q         <= inp_q + IW'(1);
					end
				end
				ST_EMIT: begin
					if (!oval_q || res.ready) begin
						oval_q   <= 1'b1;
						oidx_q   <= SLOT_IDX_W'(slot_q);
						oen_q    <= (slot_q < en);
						obusy_q  <= cur_busy;
						osrc_q   <= cur_busy ? cur_src : '0;
						ofresh_q <= fresh_q[sidx];
						osurp_q  <= SURPLUS_W'(surplus_q);
						olast_q  <= slot_last;
						if (slot_last) begin
							state_q <= ST_IDLE;
						end else begin
							slot_q <= slot_q + CW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid          = oval_q;
	assign res.slot_index     = oidx_q;
	assign res.slot_enabled   = oen_q;
	assign res.slot_busy      = obusy_q;
	assign res.source_input   = osrc_q;
	assign res.newly_assigned = ofresh_q;
	assign res.round_surplus  = osurp_q;
	assign res.last_result    = olast_q;

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rnd.valid && rnd.ready |=> !rnd.ready)
		else $error("round accepted while another is in progress");

	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.last_result |-> res.slot_index == SLOT_IDX_W'(NUM_DECODERS - 1))
		else $error("last word not on the highest slot");

	a_fresh_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.newly_assigned |-> res.slot_busy && res.slot_enabled)
		else $error("new assignment on an idle or disabled slot");

	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.slot_enabled |-> !res.slot_busy)
		else $error("disabled slot reported busy");

endmodule

FILE: hdl/stream_decoder_assigner.sv
// Sequence: each round first walks the slot table to release slots, then walks
// the waiting inputs to assign them to free slots, then emits one result word
// per slot.
// Rounds: one round at a time, set by the single walker over the slot table.
// Reset: all slots free, decoders_in_use back to 8, no word pending.
// ----------------------------------------------------------------------------
// stream_decoder_assigner
// assigns waiting input channels to decoder slots, one result word per slot
// ----------------------------------------------------------------------------
module stream_decoder_assigner
	import sda_pkg::*;
#(
	parameter int NUM_INPUTS   = 16,
	parameter int NUM_DECODERS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	sda_round_if.sink             round_req,
	sda_slot_if.source            slot_res
);

	logic [DEC_W-1:0] decoders_in_use;

	sda_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.decoders_in_use (decoders_in_use)
	);

	sda_core #(
		.NUM_INPUTS   (NUM_INPUTS),
		.NUM_DECODERS (NUM_DECODERS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.decoders_in_use (decoders_in_use),
		.rnd             (round_req),
		.res             (slot_res)
	);

endmodule

FILE: sim/tb_stream_decoder_assigner.sv
// ----------------------------------------------------------------------------
// tb_stream_decoder_assigner
// self-checking bench for the stream decoder assigner: scheduling rounds are
// driven in random bursts, every slot word is compared with a software copy
// of the slot table, and the slot count register is swept between rounds
// ----------------------------------------------------------------------------
module tb_stream_decoder_assigner;
	import sda_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS      = 8;
	localparam int CHANNELS   = 16;
	localparam int MAX_CYCLES = 200000;
	localparam int IDLE_GUARD = 8;

	typedef struct packed {
		logic [SLOT_IDX_W-1:0] slot_index;
		logic                  slot_enabled;
		logic                  slot_busy;
		logic [SRC_W-1:0]      source_input;
		logic                  newly_assigned;
		logic [SURPLUS_W-1:0]  round_surplus;
		logic                  last_result;
	} slot_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	sda_round_if round_req ();
	sda_slot_if  slot_res ();

	stream_decoder_assigner #(
		.NUM_INPUTS   (CHANNELS),
		.NUM_DECODERS (SLOTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.round_req (round_req),
		.slot_res  (slot_res)
	);

	// slot table copy and register copy
	logic             occupied [SLOTS];
	logic [SRC_W-1:0] served_by [SLOTS];
	logic [DEC_W-1:0] dec_setting;

	slot_word_t       slot_words_due [$];
	slot_word_t       got_word;
	slot_word_t       due_word;
	int               errors = 0;
	int               cycles = 0;
	int               burst_left = 0;
	logic [IN_W-1:0]  last_mask = '0;
	logic [5:0]       stall_phase = '0;
	int               stall_mode = 0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == MAX_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver stall pattern, mode picked anew each time the 6-bit phase counter wraps
	always @(posedge clk) begin
		stall_phase <= stall_phase + 6'd1;
		if (stall_phase == 6'd0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: begin
				slot_res.ready <= 1'b1;
			end
			1: begin
				slot_res.ready <= 1'($urandom_range(0, 1));
			end
			2: begin
				slot_res.ready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				slot_res.ready <= stall_phase[1];
			end
		endcase
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n === 1'b1 && slot_res.valid === 1'b1 && slot_res.ready === 1'b1) begin
			got_word.slot_index     = slot_res.slot_index;
			got_word.slot_enabled   = slot_res.slot_enabled;
			got_word.slot_busy      = slot_res.slot_busy;
			got_word.source_input   = slot_res.source_input;
			got_word.newly_assigned = slot_res.newly_assigned;
			got_word.round_surplus  = slot_res.round_surplus;
			got_word.last_result    = slot_res.last_result;
			if (slot_words_due.size() == 0) begin
				$error("slot word with none expected: slot_index %0d", got_word.slot_index);
				errors++;
			end else begin
				due_word = slot_words_due.pop_front();
				check_field("slot_index", due_word.slot_index, got_word.slot_index);
				check_field("slot_enabled", due_word.slot_enabled, got_word.slot_enabled);
				check_field("slot_busy", due_word.slot_busy, got_word.slot_busy);
				check_field("source_input", due_word.source_input, got_word.source_input);
				check_field("newly_assigned", due_word.newly_assigned,
					got_word.newly_assigned);
				check_field("round_surplus", $signed(due_word.round_surplus),
					$signed(got_word.round_surplus));
				check_field("last_result", due_word.last_result, got_word.last_result);
			end
		end
	end

	function automatic void clear_slot_table();
		for (int s = 0; s < SLOTS; s++) begin
			occupied[s]  = 1'b0;
			served_by[s] = '0;
		end
		dec_setting = DEC_RESET;
	endfunction

	// one scheduling round on the slot table copy, queues the eight slot words
	function automatic void schedule_round(input logic [IN_W-1:0] waiting);
		int               en;
		int               surplus;
		int               slot;
		logic [IN_W-1:0]  held;
		logic [SLOTS-1:0] fresh;
		slot_word_t       w;
		en      = (dec_setting > DEC_W'(SLOTS)) ? SLOTS : int'(dec_setting);
		surplus = 0;
		held    = '0;
		fresh   = '0;
		for (int s = en; s < SLOTS; s++) begin
			occupied[s]  = 1'b0;
			served_by[s] = '0;
		end
		for (int s = 0; s < en; s++) begin
			if (occupied[s]) begin
				if (!waiting[served_by[s]]) begin
					occupied[s]  = 1'b0;
					served_by[s] = '0;
					surplus++;
				end else begin
					held[served_by[s]] = 1'b1;
				end
			end
		end
		for (int i = 0; i < CHANNELS; i++) begin
			if (waiting[i] && !held[i]) begin
				slot = en;
				for (int s = en - 1; s >= 0; s--)
					if (!occupied[s])
						slot = s;
				if (slot < en) begin
					occupied[slot]  = 1'b1;
					served_by[slot] = SRC_W'(i);
					fresh[slot]     = 1'b1;
					held[i]         = 1'b1;
				end else begin
					surplus--;
				end
			end
		end
		for (int s = 0; s < SLOTS; s++) begin
			w.slot_index     = SLOT_IDX_W'(s);
			w.slot_enabled   = (s < en);
			w.slot_busy      = occupied[s];
			w.source_input   = occupied[s] ? served_by[s] : '0;
			w.newly_assigned = fresh[s];
			w.round_surplus  = SURPLUS_W'(surplus);
			w.last_result    = (s == SLOTS - 1);
			slot_words_due.push_back(w);
		end
	endfunction

	task automatic send_round(input logic [IN_W-1:0] mask);
		round_req.valid             <= 1'b1;
		round_req.input_has_samples <= mask;
		do
			@(posedge clk);
		while (round_req.ready !== 1'b1);
		schedule_round(mask);
		last_mask = mask;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			round_req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 4);
		end
	endtask

	task automatic wait_drained();
		round_req.valid <= 1'b0;
		while (slot_words_due.size() != 0)
			@(posedge clk);
		repeat (IDLE_GUARD) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
		input logic [CFG_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[2] == REG_DECODERS_IN_USE)
			dec_setting = data[DEC_W-1:0];
		@(posedge clk);
	endtask

	task automatic cfg_check_setting();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {REG_DECODERS_IN_USE, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		check_field("decoders_in_use", dec_setting, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_slot_count(input logic [DEC_W-1:0] count);
		wait_drained();
		cfg_write({REG_DECODERS_IN_USE, 2'b00}, {$urandom} & ~32'hF | CFG_DATA_W'(count));
		cfg_check_setting();
	endtask

	function automatic logic [IN_W-1:0] next_mask(input logic [IN_W-1:0] prev);
		logic [IN_W-1:0] m;
		case ($urandom_range(0, 9))
			0, 1: begin
				m = IN_W'($urandom);
			end
			2: begin
				m = IN_W'(1) << $urandom_range(0, IN_W - 1);
				m |= IN_W'(1) << $urandom_range(0, IN_W - 1);
			end
			3: begin
				m = ~(IN_W'(1) << $urandom_range(0, IN_W - 1));
			end
			4: begin
				m = prev;
			end
			default: begin
				m = prev ^ (IN_W'(1) << $urandom_range(0, IN_W - 1));
				if ($urandom_range(0, 1))
					m ^= IN_W'(1) << $urandom_range(0, IN_W - 1);
			end
		endcase
		return m;
	endfunction

	task automatic test_reset_value();
		cfg_check_setting();
	endtask

	task automatic test_directed_rounds();
		logic [IN_W-1:0] masks [10];
		masks = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001,
			16'h8000, 16'h8001, 16'hFF00, 16'h5555, 16'hAAAA};
		foreach (masks[k])
			send_round(masks[k]);
	endtask

	task automatic test_slot_counts();
		set_slot_count(4'd0);
		send_round(16'hFFFF);
		set_slot_count(4'd15);
		send_round(16'hFFFF);
		send_round(16'h0F0F);
		set_slot_count(4'd3);
		send_round(16'hF0F0);
		wait_drained();
		cfg_write(3'b100, 32'h0000_0001);
		cfg_check_setting();
		send_round(16'h0001);
		set_slot_count(4'd8);
		send_round(16'h0000);
	endtask

	task automatic test_pause_for_results();
		burst_left = 10;
		for (int k = 0; k < 4; k++)
			send_round(next_mask(last_mask));
		wait_drained();
		for (int k = 0; k < 4; k++)
			send_round(next_mask(last_mask));
	endtask

	task automatic test_random_rounds();
		logic [DEC_W-1:0] counts [6];
		counts = '{4'd8, 4'd15, 4'd1, 4'd0, 4'd5, 4'd8};
		counts[4] = DEC_W'($urandom_range(2, 7));
		foreach (counts[p]) begin
			set_slot_count(counts[p]);
			for (int k = 0; k < 20; k++)
				send_round(next_mask(last_mask));
		end
	endtask

	initial begin
		arst_n                      <= 1'b0;
		psel                        <= 1'b0;
		penable                     <= 1'b0;
		pwrite                      <= 1'b0;
		paddr                       <= '0;
		pwdata                      <= '0;
		round_req.valid             <= 1'b0;
		round_req.input_has_samples <= '0;
		clear_slot_table();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_value();
		test_directed_rounds();
		test_slot_counts();
		test_pause_for_results();
		test_random_rounds();

		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
